// ===== rtl/pio_pkg.sv =====
// ----------------------------------------------------------------------------
// pio_pkg
// shared types and constants for one port of the parallel i/o controller
// ----------------------------------------------------------------------------
package pio_pkg;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_STROBE = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_OUTPUT = 2'd0,
        MODE_INPUT  = 2'd1,
        MODE_BIDIR  = 2'd2,
        MODE_BIT    = 2'd3
    } mode_t;

    // command word low nibbles
    localparam logic [3:0] NIB_MODE     = 4'hF;
    localparam logic [3:0] NIB_INT_CTRL = 4'h7;

    // interrupt control word bits
    localparam int IC_ENABLE_BIT   = 7;
    localparam int IC_AND_BIT      = 6;
    localparam int IC_ACT_HIGH_BIT = 5;
    localparam int IC_MASK_NEXT_BIT = 4;

    localparam logic [7:0] INT_MASK_RESET = 8'hFF;

    typedef struct packed {
        action_t    action;
        logic       port_select;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_strobe;
        logic [7:0] out_data;
        logic       irq_request;
        logic [7:0] irq_vector;
    } out_item_t;

    // handshake state between the input register and the result register
    typedef struct packed {
        logic advance;
    } stage_ctl_t;

endpackage

// ===== rtl/pio_intf.sv =====
// ----------------------------------------------------------------------------
// pio input and result channels
// valid/ready channels carrying one bus item and one result item
// ----------------------------------------------------------------------------
interface pio_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       port_select;
    logic [7:0] data_byte;

    modport source (output valid, output action, output port_select, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input port_select, input data_byte,
                    output ready);
endinterface

interface pio_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       out_strobe;
    logic [7:0] out_data;
    logic       irq_request;
    logic [7:0] irq_vector;

    modport source (output valid, output read_data, output out_strobe, output out_data,
                    output irq_request, output irq_vector, input ready);
    modport sink   (input valid, input read_data, input out_strobe, input out_data,
                    input irq_request, input irq_vector, output ready);
endinterface

// ===== rtl/pio_in_stage.sv =====
// ----------------------------------------------------------------------------
// pio_in_stage
// input register: holds one accepted item until the core consumes it
// ----------------------------------------------------------------------------
module pio_in_stage
    import pio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_item_t   in_item,
    output logic       in_ready,
    input  stage_ctl_t ctl,
    output logic       item_valid,
    output in_item_t   item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || ctl.advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !ctl.advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/pio_core.sv =====
// ----------------------------------------------------------------------------
// pio_core
// port state and the decode of one item into a result and a state update
// ----------------------------------------------------------------------------
module pio_core
    import pio_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    output out_item_t result
);

    mode_t      port_mode_reg,   port_mode_next;
    logic [7:0] int_control_reg, int_control_next;
    logic [7:0] int_mask_reg,    int_mask_next;
    logic [7:0] dir_mask_reg,    dir_mask_next;
    logic [7:0] vector_reg_reg,  vector_reg_next;
    logic [7:0] last_cmd_reg,    last_cmd_next;
    logic [7:0] in_latch_reg,    in_latch_next;
    logic [7:0] out_bits_reg,    out_bits_next;
    logic       pending_reg,     pending_next;
    logic       exp_int_reg,     exp_int_next;
    logic       exp_dir_reg,     exp_dir_next;

    logic [7:0] b;
    logic [7:0] latched;
    logic [7:0] tested;
    logic [7:0] sel_bits;
    logic       strobe_taken;
    logic       bit_irq;

    assign b = item.data_byte;

    // bit mode: input pins come from the peripheral, output pins from output_bits
    assign latched  = (port_mode_reg == MODE_BIT) ? ((b & dir_mask_reg) | out_bits_reg) : b;
    assign tested   = int_control_reg[IC_ACT_HIGH_BIT] ? ~latched : latched;
    assign sel_bits = tested & dir_mask_reg;
    assign bit_irq  = int_control_reg[IC_AND_BIT] ? (sel_bits == dir_mask_reg)
                                                  : (sel_bits != 8'h00);
    assign strobe_taken = (port_mode_reg == MODE_BIT) ||
                          ((port_mode_reg != MODE_OUTPUT) && !pending_reg);

    always_comb
    begin
        port_mode_next   = port_mode_reg;
        int_control_next = int_control_reg;
        int_mask_next    = int_mask_reg;
        dir_mask_next    = dir_mask_reg;
        vector_reg_next  = vector_reg_reg;
        last_cmd_next    = last_cmd_reg;
        in_latch_next    = in_latch_reg;
        out_bits_next    = out_bits_reg;
        pending_next     = pending_reg;
        exp_int_next     = exp_int_reg;
        exp_dir_next     = exp_dir_reg;
        result           = '0;

        unique case (item.action)
            ACT_READ:
            begin
                if (item.port_select)
                begin
                    result.read_data = last_cmd_reg;
                end
                else if (port_mode_reg != MODE_OUTPUT)
                begin
                    pending_next     = 1'b0;
                    result.read_data = in_latch_reg;
                end
            end
            ACT_WRITE:
            begin
                if (item.port_select)
                begin
                    last_cmd_next = b;
                    if (exp_int_reg)
                    begin
                        int_mask_next = b;
                        exp_int_next  = 1'b0;
                    end
                    else if (exp_dir_reg)
                    begin
                        dir_mask_next = b;
                        exp_dir_next  = 1'b0;
                    end
                    else if (!b[0])
                    begin
                        vector_reg_next = b;
                    end
                    else if (b[3:0] == NIB_MODE)
                    begin
                        port_mode_next = mode_t'(b[7:6]);
                        if (mode_t'(b[7:6]) == MODE_BIT)
                        begin
                            exp_dir_next = 1'b1;
                        end
                    end
                    else if (b[3:0] == NIB_INT_CTRL)
                    begin
                        int_control_next = b;
                        if (b[IC_MASK_NEXT_BIT])
                        begin
                            exp_int_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    unique case (port_mode_reg) inside
                        MODE_OUTPUT, MODE_BIDIR:
                        begin
                            result.out_strobe = 1'b1;
                            result.out_data   = b;
                        end
                        MODE_BIT:
                        begin
                            result.out_strobe = 1'b1;
                            result.out_data   = b;
                            out_bits_next     = b & ~dir_mask_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ACT_STROBE:
            begin
                if (strobe_taken)
                begin
                    in_latch_next = latched;
                    if (port_mode_reg == MODE_INPUT || port_mode_reg == MODE_BIDIR)
                    begin
                        pending_next = 1'b1;
                    end
                    if (int_control_reg[IC_ENABLE_BIT])
                    begin
                        if (port_mode_reg == MODE_INPUT ||
                            (port_mode_reg == MODE_BIT && bit_irq))
                        begin
                            result.irq_request = 1'b1;
                            result.irq_vector  = vector_reg_reg;
                        end
                    end
                end
            end
            ACT_RESET:
            begin
                port_mode_next                  = MODE_OUTPUT;
                int_mask_next                   = INT_MASK_RESET;
                int_control_next[IC_ENABLE_BIT] = 1'b0;
                pending_next                    = 1'b0;
                exp_int_next                    = 1'b0;
                exp_dir_next                    = 1'b0;
                last_cmd_next                   = 8'h00;
                in_latch_next                   = 8'h00;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_mode_reg   <= MODE_OUTPUT;
            int_control_reg <= 8'h00;
            int_mask_reg    <= INT_MASK_RESET;
            dir_mask_reg    <= 8'h00;
            vector_reg_reg  <= 8'h00;
            last_cmd_reg    <= 8'h00;
            in_latch_reg    <= 8'h00;
            out_bits_reg    <= 8'h00;
            pending_reg     <= 1'b0;
            exp_int_reg     <= 1'b0;
            exp_dir_reg     <= 1'b0;
        end
        else if (fire)
        begin
            port_mode_reg   <= port_mode_next;
            int_control_reg <= int_control_next;
            int_mask_reg    <= int_mask_next;
            dir_mask_reg    <= dir_mask_next;
            vector_reg_reg  <= vector_reg_next;
            last_cmd_reg    <= last_cmd_next;
            in_latch_reg    <= in_latch_next;
            out_bits_reg    <= out_bits_next;
            pending_reg     <= pending_next;
            exp_int_reg     <= exp_int_next;
            exp_dir_reg     <= exp_dir_next;
        end
    end

endmodule

// ===== rtl/pio_out_stage.sv =====
// ----------------------------------------------------------------------------
// pio_out_stage
// result register: holds one result until the sink takes it
// ----------------------------------------------------------------------------
module pio_out_stage
    import pio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  out_item_t  result,
    input  logic       out_ready,
    output logic       out_valid,
    output out_item_t  out_item,
    output stage_ctl_t ctl
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    assign ctl.advance = item_valid && (!valid_reg || out_ready);
    assign valid_next  = ctl.advance || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = result_reg;

endmodule

// ===== rtl/parallel_io_port_with_interrupts.sv =====
// ----------------------------------------------------------------------------
// parallel_io_port_with_interrupts
// one port of a parallel i/o controller with interrupt on peripheral strobe
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register, then decode and port state
//   update into the result register, which a sink that is not ready stalls
// throughput: one item per cycle while the sink takes results; the port state
//   updates in the same cycle as the result register loads
// reset: rst_n clears both stages and sets the port state to its reset values
// ----------------------------------------------------------------------------
module parallel_io_port_with_interrupts
    import pio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pio_in_if.sink      in_ch,
    pio_out_if.source   out_ch
);

    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    out_item_t  result;
    out_item_t  out_item;
    stage_ctl_t ctl;

    assign in_item.action      = action_t'(in_ch.action);
    assign in_item.port_select = in_ch.port_select;
    assign in_item.data_byte   = in_ch.data_byte;

    pio_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_item    (in_item),
        .in_ready   (in_ch.ready),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item       (item)
    );

    pio_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (ctl.advance),
        .item   (item),
        .result (result)
    );

    pio_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_item   (out_item),
        .ctl        (ctl)
    );

    assign out_ch.read_data   = out_item.read_data;
    assign out_ch.out_strobe  = out_item.out_strobe;
    assign out_ch.out_data    = out_item.out_data;
    assign out_ch.irq_request = out_item.irq_request;
    assign out_ch.irq_vector  = out_item.irq_vector;

endmodule

// ===== rtl/pio_checker.sv =====
// ----------------------------------------------------------------------------
// pio_checker
// port-level checks on the parallel i/o port, bound to the top level
// ----------------------------------------------------------------------------
module pio_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic       out_strobe,
    input logic [7:0] out_data,
    input logic       irq_request,
    input logic [7:0] irq_vector
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a fresh result must come from an accepted input transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 2))
        else $error("result without a matching input transaction");

    // one item drives at most one kind of result
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_strobe && irq_request) &&
                      ((read_data == 8'h00) || (!out_strobe && !irq_request)))
        else $error("result mixes read, output and interrupt");

    // payload fields are zero unless their flag is set
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_strobe || out_data == 8'h00) &&
                      (irq_request || irq_vector == 8'h00))
        else $error("unflagged result field not zero");

endmodule

bind parallel_io_port_with_interrupts pio_checker u_pio_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .read_data   (out_ch.read_data),
    .out_strobe  (out_ch.out_strobe),
    .out_data    (out_ch.out_data),
    .irq_request (out_ch.irq_request),
    .irq_vector  (out_ch.irq_vector)
);
